// ----- hdl/sparse_triangle_conjugate_mirror_defines.svh -----
// Assertion macros shared by the checker.
`ifndef SPARSE_TRIANGLE_CONJUGATE_MIRROR_DEFINES_SVH
`define SPARSE_TRIANGLE_CONJUGATE_MIRROR_DEFINES_SVH

// Same-cycle implication, masked while in reset.
`define STCM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stcm assertion failed");

// Next-cycle implication, masked while in reset.
`define STCM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stcm assertion failed");

`endif

// ----- hdl/stcm_pkg.sv -----
package stcm_pkg;

    localparam int ROWS_DEFAULT         = 1024;
    localparam int ROW_CAPACITY_DEFAULT = 64;

    localparam int ROW_W   = 10;
    localparam int CNT_W   = 7;
    localparam int VAL_W   = 32;
    localparam int SLOT_W  = 6;

    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_ENTRY = 1'b1
    } opcode_t;

    // upper: column > row is mirrored; lower: column < row is mirrored
    typedef enum logic
    {
        MODE_UPPER = 1'b0,
        MODE_LOWER = 1'b1
    } tri_mode_t;

endpackage

// ----- hdl/stcm_in_if.sv -----
interface stcm_in_if;
    import stcm_pkg::*;

    logic                    valid;
    logic                    ready;
    opcode_t                 opcode;
    logic [ROW_W-1:0]        row;
    logic [ROW_W-1:0]        column;
    logic [CNT_W-1:0]        count;
    logic signed [VAL_W-1:0] value_real;
    logic signed [VAL_W-1:0] value_imag;

    modport source
    (
        output valid, opcode, row, column, count, value_real, value_imag,
        input  ready
    );

    modport sink
    (
        input  valid, opcode, row, column, count, value_real, value_imag,
        output ready
    );
endinterface

// ----- hdl/stcm_out_if.sv -----
interface stcm_out_if;
    import stcm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    append_valid;
    logic [ROW_W-1:0]        target_row;
    logic [SLOT_W-1:0]       target_slot;
    logic [ROW_W-1:0]        target_column;
    logic signed [VAL_W-1:0] out_real;
    logic signed [VAL_W-1:0] out_imag;
    logic                    row_full;

    modport source
    (
        output valid, append_valid, target_row, target_slot, target_column,
               out_real, out_imag, row_full,
        input  ready
    );

    modport sink
    (
        input  valid, append_valid, target_row, target_slot, target_column,
               out_real, out_imag, row_full,
        output ready
    );
endinterface

// ----- hdl/sparse_triangle_conjugate_mirror.sv -----
// Pipeline: an accepted request passes the request reg, then the result reg.
// Throughput: one request per cycle unless result.ready stalls; the fill count
//   read-modify-write in the fill memory closes through a last-write forward register.
// Reset (rst_n, async low): clears valids, forward valid and mode_reg (upper).
//   Fill memory is not cleared; a row's count is undefined until it is loaded.
module sparse_triangle_conjugate_mirror #(
    parameter int ROWS         = stcm_pkg::ROWS_DEFAULT,
    parameter int ROW_CAPACITY = stcm_pkg::ROW_CAPACITY_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    stcm_in_if.sink     feed,
    stcm_out_if.source  result,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data
);
    import stcm_pkg::*;

    localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    // counts run 0..ROW_CAPACITY inclusive
    localparam int FW = $clog2(ROW_CAPACITY + 1);

    tri_mode_t        mode_reg;

    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [FW-1:0]    rd_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [FW-1:0]    wr_data;

    // Mode register; it must be only written while the pipe is empty (the user's duty,
    // not enforced by the block itself), so the mirror stage reads it directly.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_UPPER;
        end
        else if (cfg_wr_en)
        begin
            mode_reg <= tri_mode_t'(cfg_wr_data);
        end
    end

    // Per-row fill counts: one read at request accept, one write as the
    // request leaves the mirror stage.
    stcm_fill_mem #(
        .DEPTH (ROWS),
        .WIDTH (FW)
    ) u_fill_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Triangle test, slot assignment, conjugate, result register.
    stcm_mirror #(
        .ROWS         (ROWS),
        .ROW_CAPACITY (ROW_CAPACITY)
    ) u_mirror (
        .clk     (clk),
        .rst_n   (rst_n),
        .feed    (feed),
        .result  (result),
        .mode    (mode_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule

// ----- hdl/stcm_fill_mem.sv -----
module stcm_fill_mem #(
    parameter  int DEPTH = 1024,
    parameter  int WIDTH = 7,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read returns old data on a same-address write; caller forwards
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/stcm_mirror.sv -----
module stcm_mirror #(
    parameter  int ROWS         = 1024,
    parameter  int ROW_CAPACITY = 64,
    localparam int AW           = (ROWS > 1) ? $clog2(ROWS) : 1,
    localparam int FW           = $clog2(ROW_CAPACITY + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    stcm_in_if.sink             feed,
    stcm_out_if.source          result,
    input  stcm_pkg::tri_mode_t mode,
    output logic                rd_en,
    output logic [AW-1:0]       rd_addr,
    input  logic [FW-1:0]       rd_data,
    output logic                wr_en,
    output logic [AW-1:0]       wr_addr,
    output logic [FW-1:0]       wr_data
);
    import stcm_pkg::*;

    function automatic logic [VAL_W-1:0] negate_sat(input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] min_val;
        min_val = {1'b1, {(VAL_W-1){1'b0}}};
        if (v == min_val)
            return ~min_val;
        return VAL_W'(0) - v;
    endfunction

    // stage 1: request register, fill count read in flight
    logic                    s1_valid_reg;
    opcode_t                 s1_op_reg;
    logic [ROW_W-1:0]        s1_row_reg;
    logic [ROW_W-1:0]        s1_col_reg;
    logic [CNT_W-1:0]        s1_count_reg;
    logic [VAL_W-1:0]        s1_real_reg;
    logic [VAL_W-1:0]        s1_imag_reg;

    // last fill write, covers the read that raced it
    logic                    fwd_valid_reg;
    logic [AW-1:0]           fwd_addr_reg;
    logic [FW-1:0]           fwd_data_reg;

    // result register
    logic                    res_valid_reg;
    logic                    res_append_reg;
    logic [ROW_W-1:0]        res_row_reg;
    logic [SLOT_W-1:0]       res_slot_reg;
    logic [ROW_W-1:0]        res_col_reg;
    logic [VAL_W-1:0]        res_real_reg;
    logic [VAL_W-1:0]        res_imag_reg;
    logic                    res_full_reg;

    logic                    s1_adv;
    logic                    accept;
    logic [AW-1:0]           col_addr;
    logic [FW-1:0]           fill;
    logic                    row_ok;
    logic                    col_ok;
    logic                    in_tri;
    logic                    hit;
    logic                    full;
    logic                    append;
    logic [FW-1:0]           cnt_sat;

    logic                    res_append_next;
    logic [ROW_W-1:0]        res_row_next;
    logic [SLOT_W-1:0]       res_slot_next;
    logic [ROW_W-1:0]        res_col_next;
    logic [VAL_W-1:0]        res_real_next;
    logic [VAL_W-1:0]        res_imag_next;
    logic                    res_full_next;

    assign s1_adv     = s1_valid_reg && (!res_valid_reg || result.ready);
    assign feed.ready = !s1_valid_reg || s1_adv;
    assign accept     = feed.valid && feed.ready;

    assign rd_en   = accept;
    assign rd_addr = AW'(feed.column);

    assign col_addr = AW'(s1_col_reg);
    assign fill     = (fwd_valid_reg && fwd_addr_reg == col_addr) ? fwd_data_reg : rd_data;

    always_comb
    begin
        row_ok  = 32'(s1_row_reg) < 32'(ROWS);
        col_ok  = 32'(s1_col_reg) < 32'(ROWS);
        in_tri  = (mode == MODE_LOWER) ? (s1_col_reg < s1_row_reg)
                                       : (s1_col_reg > s1_row_reg);
        hit     = (s1_op_reg == OP_ENTRY) && row_ok && col_ok && in_tri;
        full    = 32'(fill) >= 32'(ROW_CAPACITY);
        append  = hit && !full;
        cnt_sat = (32'(s1_count_reg) > 32'(ROW_CAPACITY)) ? FW'(ROW_CAPACITY)
                                                          : FW'(s1_count_reg);

        res_append_next = append;
        res_full_next   = hit && full;
        res_row_next    = hit ? s1_col_reg : '0;
        res_col_next    = hit ? s1_row_reg : '0;
        res_slot_next   = append ? SLOT_W'(fill) : '0;
        res_real_next   = append ? s1_real_reg : '0;
        res_imag_next   = append ? negate_sat(s1_imag_reg) : '0;

        if (s1_op_reg == OP_LOAD)
        begin
            wr_en   = s1_adv && row_ok;
            wr_addr = AW'(s1_row_reg);
            wr_data = cnt_sat;
        end
        else
        begin
            wr_en   = s1_adv && append;
            wr_addr = col_addr;
            wr_data = fill + FW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (feed.ready)
            begin
                s1_valid_reg <= feed.valid;
            end
            if (wr_en)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (s1_adv)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= feed.opcode;
            s1_row_reg   <= feed.row;
            s1_col_reg   <= feed.column;
            s1_count_reg <= feed.count;
            s1_real_reg  <= feed.value_real;
            s1_imag_reg  <= feed.value_imag;
        end
        if (wr_en)
        begin
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= wr_data;
        end
        if (s1_adv)
        begin
            res_append_reg <= res_append_next;
            res_row_reg    <= res_row_next;
            res_slot_reg   <= res_slot_next;
            res_col_reg    <= res_col_next;
            res_real_reg   <= res_real_next;
            res_imag_reg   <= res_imag_next;
            res_full_reg   <= res_full_next;
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.append_valid  = res_append_reg;
    assign result.target_row    = res_row_reg;
    assign result.target_slot   = res_slot_reg;
    assign result.target_column = res_col_reg;
    assign result.out_real      = res_real_reg;
    assign result.out_imag      = res_imag_reg;
    assign result.row_full      = res_full_reg;

endmodule

// ----- hdl/stcm_checker.sv -----
`include "sparse_triangle_conjugate_mirror_defines.svh"

module stcm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic        append_valid,
    input logic [5:0]  target_slot,
    input logic [31:0] out_real,
    input logic [31:0] out_imag,
    input logic        row_full
);

    // a stalled result stays offered
    `STCM_ASSERT_NXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid)

    // a dropped append never also reports an append
    `STCM_ASSERT_IMP(a_full_excl, clk, rst_n, res_valid && row_full, !append_valid)

    // no append: slot and value are zero
    `STCM_ASSERT_IMP(a_zero_fields, clk, rst_n, res_valid && !append_valid,
        target_slot == 6'd0 && out_real == 32'd0 && out_imag == 32'd0)

    // saturating negate never yields the most negative value
    `STCM_ASSERT_IMP(a_imag_sat, clk, rst_n, res_valid, out_imag != 32'h8000_0000)

endmodule

bind sparse_triangle_conjugate_mirror stcm_checker u_stcm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .append_valid (result.append_valid),
    .target_slot  (result.target_slot),
    .out_real     (result.out_real),
    .out_imag     (result.out_imag),
    .row_full     (result.row_full)
);
